>>> hdl/pcs_pkg.sv
// Shared types, constants and the relay entry table of the precharge contactor sequencer.
package pcs_pkg;

  localparam int OpW      = 3;
  localparam int ModeW    = 3;
  localparam int SupplyW  = 16;
  localparam int MarginW  = 15;
  localparam int TickW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  // Width of the signed difference target minus supply; it cannot wrap.
  localparam int DiffW    = SupplyW + 1;

  localparam logic signed [SupplyW-1:0] TargetMvReset = 16'sd13000;
  localparam logic [MarginW-1:0]        MarginMvReset = 15'd1000;
  localparam logic [TickW-1:0]          On1WaitReset  = 8'd30;
  localparam logic [TickW-1:0]          On2WaitReset  = 8'd10;
  localparam logic [TickW-1:0]          Pre1WaitReset = 8'd10;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT = 3'd0,
    MODE_OFF  = 3'd1,
    MODE_ON1  = 3'd2,
    MODE_ON2  = 3'd3,
    MODE_ON   = 3'd4,
    MODE_PRE1 = 3'd5,
    MODE_PRE  = 3'd6
  } mode_t;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_ON    = 3'd1,
    OP_OFF   = 3'd2,
    OP_PRE   = 3'd3,
    OP_RESET = 3'd4
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_MV   = 3'd0,
    REG_MARGIN_MV   = 3'd1,
    REG_ON1_WAIT    = 3'd2,
    REG_ON2_WAIT    = 3'd3,
    REG_PRE1_WAIT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic reset_relay;
    logic precharge;
    logic main_low;
    logic main_high;
  } relay_t;

  // Relay levels applied when a mode is entered. Precharge stage one keeps
  // the main high relay as it was.
  function automatic relay_t relays_on_entry(mode_t m, relay_t cur);
    relay_t r;
    r = cur;
    case (m)
      MODE_OFF:  r = '{reset_relay: 1'b0, precharge: 1'b0, main_low: 1'b0, main_high: 1'b0};
      MODE_ON1:  r = '{reset_relay: 1'b1, precharge: 1'b1, main_low: 1'b1, main_high: 1'b0};
      MODE_ON2:  r = '{reset_relay: 1'b1, precharge: 1'b1, main_low: 1'b1, main_high: 1'b1};
      MODE_ON:   r = '{reset_relay: 1'b0, precharge: 1'b0, main_low: 1'b1, main_high: 1'b1};
      MODE_PRE1: r = '{reset_relay: 1'b1, precharge: 1'b1, main_low: 1'b1,
                       main_high: cur.main_high};
      MODE_PRE:  r = '{reset_relay: 1'b1, precharge: 1'b1, main_low: 1'b1, main_high: 1'b0};
      default:   r = cur;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/pcs_cmd_if.sv
// Command channel of the sequencer: valid, ready, operation code and supply sample.
interface pcs_cmd_if;
  import pcs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OpW-1:0]            op;
  logic signed [SupplyW-1:0] supply_mv;

  modport source (output valid, output op, output supply_mv, input ready);
  modport sink   (input valid, input op, input supply_mv, output ready);
endinterface

>>> hdl/pcs_res_if.sv
// Result channel of the sequencer: valid, ready, mode and the four relay levels.
interface pcs_res_if;
  import pcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] device_mode;
  logic             main_high_closed;
  logic             main_low_closed;
  logic             precharge_closed;
  logic             reset_relay_closed;

  modport source (output valid, output device_mode, output main_high_closed,
                  output main_low_closed, output precharge_closed,
                  output reset_relay_closed, input ready);
  modport sink   (input valid, input device_mode, input main_high_closed,
                  input main_low_closed, input precharge_closed,
                  input reset_relay_closed, output ready);
endinterface

>>> hdl/precharge_contactor_sequencer.sv
// Precharge contactor sequencer: seven-mode relay controller driven by commands and ticks.
//
//   Channel  Dir  Handshake      Payload
//   cmd      in   valid/ready    op (3), supply_mv (16 signed)
//   res      out  valid/ready    device_mode (3), four relay levels (1 each)
//   cfg      in   cfg_we only    cfg_index (3), cfg_data (16)
//
// Every command transfer yields exactly one result transfer. A command is
// captured in the input register, then evaluated against the mode, tick
// count and relay registers once the result slot is free; those state
// registers are the result register. A command thus passes the input
// register and then the state registers before its result is valid, and
// one command per cycle is sustained while results are taken. A stalled
// result holds the state; the input register still takes one more command,
// after which cmd.ready drops until the result is taken. Reset (rst,
// synchronous) puts the block in init mode with all relays open and loads the default configuration.
module precharge_contactor_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  pcs_cmd_if.sink                         cmd,
  pcs_res_if.source                       res,
  input  logic                            cfg_we,
  input  logic [pcs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pcs_pkg::CfgDataW-1:0]    cfg_data
);
  import pcs_pkg::*;

  // Configuration registers.
  logic signed [SupplyW-1:0] target_mv;
  logic [MarginW-1:0]        margin_mv;
  logic [TickW-1:0]          on1_wait_ticks;
  logic [TickW-1:0]          on2_wait_ticks;
  logic [TickW-1:0]          pre1_wait_ticks;

  // Input register.
  logic                      in_valid;
  logic [OpW-1:0]            op_q;
  logic signed [SupplyW-1:0] supply_q;

  // Sequencer state, which doubles as the result register.
  logic                      out_valid;
  mode_t                     mode, mode_next;
  logic [TickW-1:0]          tick_count, tick_count_next;
  relay_t                    relays, relays_next;

  // Evaluation fires when an item is held and the result slot is free or
  // being emptied in this cycle.
  logic                      eval_fire;
  logic                      in_load;

  logic                      do_enter;
  mode_t                     enter_mode;
  logic [TickW-1:0]          tick_inc;
  logic signed [DiffW-1:0]   diff;
  logic                      charged;

  assign eval_fire = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || eval_fire;
  assign in_load   = cmd.valid && cmd.ready;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_mv       <= TargetMvReset;
      margin_mv       <= MarginMvReset;
      on1_wait_ticks  <= On1WaitReset;
      on2_wait_ticks  <= On2WaitReset;
      pre1_wait_ticks <= Pre1WaitReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_MV: target_mv       <= $signed(cfg_data[SupplyW-1:0]);
        REG_MARGIN_MV: margin_mv       <= cfg_data[MarginW-1:0];
        REG_ON1_WAIT:  on1_wait_ticks  <= cfg_data[TickW-1:0];
        REG_ON2_WAIT:  on2_wait_ticks  <= cfg_data[TickW-1:0];
        REG_PRE1_WAIT: pre1_wait_ticks <= cfg_data[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: valid bit is control, payload loads on transfer only.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (eval_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      op_q     <= cmd.op;
      supply_q <= cmd.supply_mv;
    end
  end

  // The supply counts as charged when it is at or above target, or when the
  // shortfall is below the margin. The difference is one bit wider than the
  // operands so it never wraps.
  assign diff    = DiffW'(target_mv) - DiffW'(supply_q);
  assign charged = (diff <= 0) || (diff < $signed({2'b00, margin_mv}));
  assign tick_inc = tick_count + TickW'(1);

  // Next state for the item held in the input register.
  always_comb begin
    do_enter        = 1'b0;
    enter_mode      = MODE_OFF;
    tick_count_next = tick_count;
    case (mode)
      MODE_OFF: begin
        case (op_t'(op_q))
          OP_ON: begin
            do_enter   = 1'b1;
            enter_mode = MODE_ON1;
          end
          OP_PRE: begin
            do_enter   = 1'b1;
            enter_mode = MODE_PRE1;
          end
          OP_RESET: begin
            do_enter   = 1'b1;
            enter_mode = MODE_OFF;
          end
          default: begin
          end
        endcase
      end
      MODE_ON1, MODE_ON2, MODE_PRE1: begin
        case (op_t'(op_q))
          OP_TICK: begin
            tick_count_next = tick_inc;
            if (mode == MODE_ON1 && tick_inc == on1_wait_ticks) begin
              // End of stage one: advance when charged, else retry stage one.
              do_enter   = 1'b1;
              enter_mode = charged ? MODE_ON2 : MODE_ON1;
            end else if (mode == MODE_ON2 && tick_inc == on2_wait_ticks) begin
              do_enter   = 1'b1;
              enter_mode = MODE_ON;
            end else if (mode == MODE_PRE1 && tick_inc == pre1_wait_ticks) begin
              do_enter   = 1'b1;
              enter_mode = MODE_PRE;
            end
          end
          OP_OFF, OP_RESET: begin
            do_enter   = 1'b1;
            enter_mode = MODE_OFF;
          end
          OP_PRE: begin
            if (mode != MODE_PRE1) begin
              do_enter   = 1'b1;
              enter_mode = MODE_PRE1;
            end
          end
          OP_ON: begin
            if (mode == MODE_PRE1) begin
              do_enter   = 1'b1;
              enter_mode = MODE_ON1;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_ON, MODE_PRE: begin
        case (op_t'(op_q))
          OP_OFF, OP_RESET: begin
            do_enter   = 1'b1;
            enter_mode = MODE_OFF;
          end
          OP_PRE: begin
            if (mode == MODE_ON) begin
              do_enter   = 1'b1;
              enter_mode = MODE_PRE1;
            end
          end
          OP_ON: begin
            if (mode == MODE_PRE) begin
              do_enter   = 1'b1;
              enter_mode = MODE_ON1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        // Init, and the unused mode code: any item enters off.
        do_enter   = 1'b1;
        enter_mode = MODE_OFF;
      end
    endcase

    mode_next   = mode;
    relays_next = relays;
    if (do_enter) begin
      mode_next       = enter_mode;
      tick_count_next = '0;
      relays_next     = relays_on_entry(enter_mode, relays);
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_INIT;
      tick_count <= '0;
      relays     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (eval_fire) begin
        mode       <= mode_next;
        tick_count <= tick_count_next;
        relays     <= relays_next;
        out_valid  <= 1'b1;
      end else if (res.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign res.valid              = out_valid;
  assign res.device_mode        = mode;
  assign res.main_high_closed   = relays.main_high;
  assign res.main_low_closed    = relays.main_low;
  assign res.precharge_closed   = relays.precharge;
  assign res.reset_relay_closed = relays.reset_relay;

  // Off mode always has every relay open.
  a_off_all_open: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_OFF) |-> (relays == '0))
    else $error("relays closed in off mode");

  // Only the timed stages ever hold a nonzero tick count.
  a_tick_only_timed: assert property (@(posedge clk) disable iff (rst)
    (tick_count != '0) |->
      (mode == MODE_ON1 || mode == MODE_ON2 || mode == MODE_PRE1))
    else $error("tick count running outside a timed stage");

  // Main high closed with precharge open is only the fully on mode.
  a_high_without_pre: assert property (@(posedge clk) disable iff (rst)
    (relays.main_high && !relays.precharge) |-> (mode == MODE_ON))
    else $error("main high closed without precharge outside on mode");

  // With the input register full and the result stalled, no command is taken.
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !res.ready) |-> !cmd.ready)
    else $error("command accepted while both stages are blocked");

endmodule
